/* src/ffba_pkg.sv */
// first-fit block allocator: shared constants, types and helpers
// no dependencies; imported by ffba_hdr_mem, first_fit_block_allocator_top, ffba_checker and testbench
`timescale 1ns / 1ps

package ffba_pkg;

	// managed region and header store geometry
	localparam int REGION_BYTES = 65536;
	localparam int STORE_DEPTH  = REGION_BYTES / 4;
	localparam int OFF_W        = $clog2(REGION_BYTES) + 1;
	localparam int IDX_W        = $clog2(STORE_DEPTH);
	localparam int CNT_W        = IDX_W + 1;

	// fixed field widths
	localparam int ADDR_W    = 32;
	localparam int REQ_W     = 17;
	localparam int RSIZE_W   = 17;
	localparam int CFG_IDX_W = 1;

	// width for sums and compares of offsets and sizes
	localparam int CMP_W = ((REQ_W > OFF_W) ? REQ_W : OFF_W) + 3;

	localparam int HDR_BYTES   = 8;
	localparam int ALIGN_BYTES = 4;
	localparam int SPLIT_LIMIT = ALIGN_BYTES + HDR_BYTES;

	// operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 1'b1;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		A_TEST,
		A_EVAL,
		A_WNEW,
		A_WCUR,
		A_WPREV,
		F_CHK,
		F_SZ,
		F_TEST,
		F_STEP,
		F_DECIDE,
		F_NEXT,
		F_WOFF,
		F_WPREV,
		S_DONE
	} state_t;

	// header store access: one address, separate write enables
	typedef struct packed {
		logic [IDX_W-1:0] addr;
		logic             we_size;
		logic             we_link;
		logic [OFF_W-1:0] size;
		logic [OFF_W-1:0] link;
	} mem_req_t;

	// header offset to store index, out-of-store offsets fold to index 0
	function automatic logic [IDX_W-1:0] slot(input logic [OFF_W-1:0] off);
		logic [IDX_W-1:0] idx;
		if (off[OFF_W-1:2] < (OFF_W-2)'(STORE_DEPTH)) begin
			idx = off[2 +: IDX_W];
		end else begin
			idx = '0;
		end
		return idx;
	endfunction

endpackage

/* src/ffba_hdr_mem.sv */
// header store: block size and next-free link per 4-byte header slot
// depends on ffba_pkg for geometry and the request struct
`timescale 1ns / 1ps

module ffba_hdr_mem (
	input  logic                    clk,
	input  ffba_pkg::mem_req_t      req,
	output logic [ffba_pkg::OFF_W-1:0] rd_size,
	output logic [ffba_pkg::OFF_W-1:0] rd_link
);
	import ffba_pkg::*;

	logic [OFF_W-1:0] size_mem [STORE_DEPTH];
	logic [OFF_W-1:0] link_mem [STORE_DEPTH];
	logic [OFF_W-1:0] rd_size_q;
	logic [OFF_W-1:0] rd_link_q;

	// single port per array, registered read
	always_ff @(posedge clk) begin
		if (req.we_size) begin
			size_mem[req.addr] <= req.size;
		end
		rd_size_q <= size_mem[req.addr];
	end

	always_ff @(posedge clk) begin
		if (req.we_link) begin
			link_mem[req.addr] <= req.link;
		end
		rd_link_q <= link_mem[req.addr];
	end

	assign rd_size = rd_size_q;
	assign rd_link = rd_link_q;

endmodule

/* src/first_fit_block_allocator_top.sv */
// first-fit block allocator with address-ordered free list and coalescing
// depends on ffba_pkg and ffba_hdr_mem
//
// channel   direction  signals                                    transfer
// command   in         start, op, request_size, block_addr        start & !busy
// result    out        done, block_address, success               done (one cycle)
// config    in         cfg_we, cfg_index, cfg_data                cfg_we
//
// allocate: walks the free list to the first fit, then up to 3 header writes
// free: range and size checks, a walk past free blocks below the address, then up to 2 header writes
// the list walk reads one header at a time from the single-port store
// after reset the init state writes the initial free header (busy high)
// the result cannot be stalled; busy stays high through the done cycle
`timescale 1ns / 1ps

module first_fit_block_allocator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              op,
	input  logic [ffba_pkg::REQ_W-1:0]        request_size,
	input  logic [ffba_pkg::ADDR_W-1:0]       block_addr,
	output logic                              done,
	output logic [ffba_pkg::ADDR_W-1:0]       block_address,
	output logic                              success,
	input  logic                              cfg_we,
	input  logic [ffba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ffba_pkg::ADDR_W-1:0]       cfg_data
);
	import ffba_pkg::*;

	state_t state_q, state_d;

	logic [ADDR_W-1:0] base_q;
	logic [OFF_W-1:0]  len_q;
	logic [OFF_W-1:0]  first_q;
	logic [OFF_W-1:0]  cur_q, prev_q, prev_size_q, off_q, sz_q;
	logic [CMP_W-1:0]  need_q;
	logic [OFF_W-1:0]  have_q, after_q, nsz_q, nlink_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              split_q;
	logic [ADDR_W-1:0] off32_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              res_ok_q;

	logic [OFF_W-1:0]  rd_size, rd_link;
	mem_req_t          fsm_req, mem_req;

	// config decode
	logic              cfg_size_wr;
	logic [RSIZE_W-1:0] cfg_size;
	logic [OFF_W-1:0]  cfg_len;
	assign cfg_size_wr = cfg_we && (cfg_index == CFG_REGION_SIZE);
	assign cfg_size    = cfg_data[RSIZE_W-1:0];
	assign cfg_len     = (CMP_W'(cfg_size) < CMP_W'(REGION_BYTES)) ?
		OFF_W'(cfg_size) : OFF_W'(REGION_BYTES);

	// arithmetic shared by the walk and the checks
	logic [CMP_W-1:0] need_rnd;
	logic [OFF_W-1:0] nb_off;
	logic [CMP_W-1:0] off_end;
	logic [CMP_W-1:0] prev_end;
	logic [ADDR_W:0]  off32_hdr;
	assign need_rnd  = (CMP_W'(request_size) + CMP_W'(ALIGN_BYTES - 1)) &
		~CMP_W'(ALIGN_BYTES - 1);
	assign nb_off    = OFF_W'(CMP_W'(cur_q) + CMP_W'(need_q) + CMP_W'(HDR_BYTES));
	assign off_end   = CMP_W'(off_q) + CMP_W'(HDR_BYTES) + CMP_W'(sz_q);
	assign prev_end  = CMP_W'(prev_q) + CMP_W'(HDR_BYTES) + CMP_W'(prev_size_q);
	assign off32_hdr = {1'b0, off32_q} + (ADDR_W+1)'(HDR_BYTES);

	// decision flags
	logic a_miss, a_fit, f_bad_rng, f_bad_sz, f_walk, f_reject, f_mnext, f_mprev;
	logic [OFF_W-1:0] repl;
	assign a_miss    = (cur_q == '0) || (cnt_q == CNT_W'(STORE_DEPTH));
	assign a_fit     = CMP_W'(rd_size) >= CMP_W'(need_q);
	assign f_bad_rng = (off32_q < ADDR_W'(HDR_BYTES)) || (off32_q[1:0] != 2'b00) ||
		(off32_hdr > (ADDR_W+1)'(len_q));
	assign f_bad_sz  = (CMP_W'(off_q) + CMP_W'(HDR_BYTES) + CMP_W'(rd_size)) >
		CMP_W'(len_q);
	assign f_walk    = (cur_q != '0) && (cur_q < off_q) &&
		(cnt_q < CNT_W'(STORE_DEPTH));
	assign f_reject  = (cur_q == off_q) ||
		((prev_q != '0) && (prev_end > CMP_W'(off_q))) ||
		((cur_q != '0) && (off_end > CMP_W'(cur_q)));
	assign f_mnext   = (cur_q != '0) && (off_end == CMP_W'(cur_q));
	assign f_mprev   = prev_end == CMP_W'(off_q);
	assign repl      = split_q ? nb_off : after_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT:   state_d = S_IDLE;
			S_IDLE: begin
				if (start) begin
					state_d = (op == OP_ALLOC) ? A_TEST : F_CHK;
				end
			end
			A_TEST:   state_d = a_miss ? S_DONE : A_EVAL;
			A_EVAL: begin
				if (a_fit) begin
					state_d = ((CMP_W'(rd_size) - need_q) > CMP_W'(SPLIT_LIMIT)) ?
						A_WNEW : A_WCUR;
				end else begin
					state_d = A_TEST;
				end
			end
			A_WNEW:   state_d = A_WCUR;
			A_WCUR:   state_d = (prev_q != '0) ? A_WPREV : S_DONE;
			A_WPREV:  state_d = S_DONE;
			F_CHK:    state_d = f_bad_rng ? S_DONE : F_SZ;
			F_SZ:     state_d = f_bad_sz ? S_DONE : F_TEST;
			F_TEST:   state_d = f_walk ? F_STEP : F_DECIDE;
			F_STEP:   state_d = F_TEST;
			F_DECIDE: begin
				priority if (f_reject) begin
					state_d = S_DONE;
				end else if (f_mnext) begin
					state_d = F_NEXT;
				end else begin
					state_d = F_WOFF;
				end
			end
			F_NEXT:   state_d = F_WOFF;
			F_WOFF:   state_d = (prev_q != '0) ? F_WPREV : S_DONE;
			F_WPREV:  state_d = S_DONE;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// store access per state
	always_comb begin
		fsm_req = '0;
		unique case (state_q)
			A_TEST: fsm_req.addr = slot(cur_q);
			A_WNEW: begin
				fsm_req.addr    = slot(nb_off);
				fsm_req.we_size = 1'b1;
				fsm_req.we_link = 1'b1;
				fsm_req.size    = OFF_W'(CMP_W'(have_q) - CMP_W'(need_q) -
					CMP_W'(HDR_BYTES));
				fsm_req.link    = after_q;
			end
			A_WCUR: begin
				fsm_req.addr    = slot(cur_q);
				fsm_req.we_size = 1'b1;
				fsm_req.we_link = 1'b1;
				fsm_req.size    = split_q ? OFF_W'(need_q) : have_q;
				fsm_req.link    = '0;
			end
			A_WPREV: begin
				fsm_req.addr    = slot(prev_q);
				fsm_req.we_link = 1'b1;
				fsm_req.link    = repl;
			end
			F_CHK:  fsm_req.addr = slot(off32_q[OFF_W-1:0]);
			F_TEST: fsm_req.addr = slot(cur_q);
			F_DECIDE: fsm_req.addr = slot(cur_q);
			F_WOFF: begin
				fsm_req.addr    = slot(off_q);
				fsm_req.we_size = 1'b1;
				fsm_req.we_link = 1'b1;
				fsm_req.size    = nsz_q;
				fsm_req.link    = nlink_q;
			end
			F_WPREV: begin
				fsm_req.addr    = slot(prev_q);
				fsm_req.we_size = 1'b1;
				fsm_req.we_link = 1'b1;
				fsm_req.size    = f_mprev ? OFF_W'(CMP_W'(prev_size_q) + CMP_W'(nsz_q) +
					CMP_W'(HDR_BYTES)) : prev_size_q;
				fsm_req.link    = f_mprev ? nlink_q : off_q;
			end
			default: fsm_req = '0;
		endcase
	end

	// region init write wins; user keeps it to idle or reset, block does not check
	always_comb begin
		mem_req = fsm_req;
		if (cfg_size_wr) begin
			mem_req.addr    = slot(OFF_W'(HDR_BYTES));
			mem_req.we_size = (cfg_len >= OFF_W'(2 * HDR_BYTES));
			mem_req.we_link = (cfg_len >= OFF_W'(2 * HDR_BYTES));
			mem_req.size    = cfg_len - OFF_W'(2 * HDR_BYTES);
			mem_req.link    = '0;
		end else if (state_q == S_INIT) begin
			mem_req.addr    = slot(OFF_W'(HDR_BYTES));
			mem_req.we_size = 1'b1;
			mem_req.we_link = 1'b1;
			mem_req.size    = OFF_W'(REGION_BYTES - 2 * HDR_BYTES);
			mem_req.link    = '0;
		end
	end

	ffba_hdr_mem u_hdr_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_size (rd_size),
		.rd_link (rd_link)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			base_q  <= '0;
			len_q   <= OFF_W'(REGION_BYTES);
			first_q <= OFF_W'(HDR_BYTES);
		end else begin
			state_q <= state_d;
			if (cfg_we && (cfg_index == CFG_REGION_BASE)) begin
				base_q <= cfg_data;
			end
			if (cfg_size_wr) begin
				len_q   <= cfg_len;
				first_q <= (cfg_len >= OFF_W'(2 * HDR_BYTES)) ? OFF_W'(HDR_BYTES) : '0;
			end else if (state_q == A_WCUR && prev_q == '0) begin
				first_q <= repl;
			end else if (state_q == F_WOFF && prev_q == '0) begin
				first_q <= off_q;
			end
		end
	end

	// walk and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				need_q  <= need_rnd;
				off32_q <= block_addr - base_q;
				cur_q   <= first_q;
				prev_q  <= '0;
				cnt_q   <= '0;
				res_ok_q   <= 1'b0;
				res_addr_q <= '0;
			end
			A_EVAL: begin
				if (a_fit) begin
					have_q  <= rd_size;
					after_q <= rd_link;
					split_q <= (CMP_W'(rd_size) - need_q) > CMP_W'(SPLIT_LIMIT);
				end else begin
					prev_q <= cur_q;
					cur_q  <= rd_link;
					cnt_q  <= cnt_q + 1'b1;
				end
			end
			A_WCUR: begin
				if (prev_q == '0) begin
					res_ok_q   <= 1'b1;
					res_addr_q <= base_q + ADDR_W'(cur_q);
				end
			end
			A_WPREV: begin
				res_ok_q   <= 1'b1;
				res_addr_q <= base_q + ADDR_W'(cur_q);
			end
			F_CHK:  off_q <= off32_q[OFF_W-1:0];
			F_SZ:   sz_q  <= rd_size;
			F_STEP: begin
				prev_q      <= cur_q;
				prev_size_q <= rd_size;
				cur_q       <= rd_link;
				cnt_q       <= cnt_q + 1'b1;
			end
			F_DECIDE: begin
				nsz_q   <= sz_q;
				nlink_q <= cur_q;
			end
			F_NEXT: begin
				nsz_q   <= OFF_W'(CMP_W'(sz_q) + CMP_W'(rd_size) + CMP_W'(HDR_BYTES));
				nlink_q <= rd_link;
			end
			F_WOFF:  res_ok_q <= (prev_q == '0);
			F_WPREV: res_ok_q <= 1'b1;
			default: ;
		endcase
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = (state_q == S_DONE);
	assign block_address = res_addr_q;
	assign success       = res_ok_q;

	// an accepted command always occupies the block
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not make the block busy");

	// the block is free again right after delivering a result
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after result");

	// a failed request reports a zero address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !success) |-> (block_address == '0))
		else $error("failed request reports a nonzero address");

endmodule

/* tb/ffba_checker.sv */
// first-fit block allocator checker: watches command, result and config channels
// keeps its own free list model, predicts each result and compares; needs ffba_pkg
`timescale 1ns / 1ps

module ffba_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic                           op,
	input  logic [ffba_pkg::REQ_W-1:0]     request_size,
	input  logic [ffba_pkg::ADDR_W-1:0]    block_addr,
	input  logic                           done,
	input  logic [ffba_pkg::ADDR_W-1:0]    block_address,
	input  logic                           success,
	input  logic                           cfg_we,
	input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffba_pkg::ADDR_W-1:0]    cfg_data,
	output int                             fail_count,
	output int                             pending,
	output int                             results_seen
);
	import ffba_pkg::*;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              ok;
	} outcome_t;

	// shadow header store and list head
	bit [OFF_W-1:0] size_shadow [STORE_DEPTH];
	bit [OFF_W-1:0] link_shadow [STORE_DEPTH];
	bit [31:0]      head_off;
	bit [31:0]      base_shadow;
	bit [31:0]      rsize_shadow;
	outcome_t       outcome_q [$];

	assign pending = outcome_q.size();

	function automatic bit [31:0] usable_len();
		return (rsize_shadow < REGION_BYTES) ? rsize_shadow : REGION_BYTES;
	endfunction

	function automatic int idx_of(bit [31:0] off);
		return ((off >> 2) < STORE_DEPTH) ? int'(off >> 2) : 0;
	endfunction

	// region becomes one free block at offset 8 when it is at least 16 bytes long
	function automatic void build_region();
		bit [31:0] len;
		len = usable_len();
		if (len >= 2 * HDR_BYTES) begin
			size_shadow[idx_of(HDR_BYTES)] = OFF_W'(len - 2 * HDR_BYTES);
			link_shadow[idx_of(HDR_BYTES)] = '0;
			head_off = HDR_BYTES;
		end else begin
			head_off = 0;
		end
	endfunction

	// first-fit search with optional split
	function automatic outcome_t predict_alloc(bit [31:0] req);
		outcome_t  res;
		bit [31:0] need, prev, cur, have, after, repl, nb;
		int        n;
		need = (req + ALIGN_BYTES - 1) & ~32'(ALIGN_BYTES - 1);
		prev = 0;
		cur = head_off;
		res = '0;
		for (n = 0; cur != 0 && n < STORE_DEPTH; n++) begin
			if (size_shadow[idx_of(cur)] >= need) break;
			prev = cur;
			cur = link_shadow[idx_of(cur)];
		end
		if (cur == 0 || n >= STORE_DEPTH) return res;
		have = size_shadow[idx_of(cur)];
		after = link_shadow[idx_of(cur)];
		repl = after;
		if (have - need > SPLIT_LIMIT) begin
			nb = cur + need + HDR_BYTES;
			size_shadow[idx_of(nb)] = OFF_W'(have - need - HDR_BYTES);
			link_shadow[idx_of(nb)] = OFF_W'(after);
			size_shadow[idx_of(cur)] = OFF_W'(need);
			repl = nb;
		end
		if (prev == 0) head_off = repl;
		else link_shadow[idx_of(prev)] = OFF_W'(repl);
		link_shadow[idx_of(cur)] = '0;
		res.addr = base_shadow + cur;
		res.ok = 1'b1;
		return res;
	endfunction

	// ordered insert with neighbour merge, rejects range errors and overlaps
	function automatic bit predict_free(bit [31:0] baddr);
		longint    len;
		bit [31:0] off, sz, prev, cur;
		int        n;
		len = usable_len();
		off = baddr - base_shadow;
		prev = 0;
		cur = head_off;
		if (off < HDR_BYTES || off[1:0] != 2'b00) return 0;
		if (longint'(off) + HDR_BYTES > len) return 0;
		sz = size_shadow[idx_of(off)];
		if (longint'(off) + HDR_BYTES + sz > len) return 0;
		for (n = 0; cur != 0 && cur < off && n < STORE_DEPTH; n++) begin
			prev = cur;
			cur = link_shadow[idx_of(cur)];
		end
		if (cur == off) return 0;
		if (prev != 0 && longint'(prev) + HDR_BYTES + size_shadow[idx_of(prev)] > off)
			return 0;
		if (cur != 0 && longint'(off) + HDR_BYTES + sz > cur) return 0;
		link_shadow[idx_of(off)] = OFF_W'(cur);
		if (prev == 0) head_off = off;
		else link_shadow[idx_of(prev)] = OFF_W'(off);
		if (cur != 0 && off + HDR_BYTES + sz == cur) begin
			size_shadow[idx_of(off)] = OFF_W'(sz + size_shadow[idx_of(cur)] + HDR_BYTES);
			link_shadow[idx_of(off)] = link_shadow[idx_of(cur)];
		end
		if (prev != 0 && prev + HDR_BYTES + size_shadow[idx_of(prev)] == off) begin
			size_shadow[idx_of(prev)] = OFF_W'(size_shadow[idx_of(prev)]
				+ size_shadow[idx_of(off)] + HDR_BYTES);
			link_shadow[idx_of(prev)] = link_shadow[idx_of(off)];
		end
		return 1;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		$display("%0t mismatch %s: expected %h got %h", $time, what, want, got);
		fail_count++;
	endtask

	// predict on every command transfer, compare on every result
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++) begin
				size_shadow[i] = '0;
				link_shadow[i] = '0;
			end
			base_shadow = 0;
			rsize_shadow = REGION_BYTES;
			build_region();
			outcome_q.delete();
			fail_count = 0;
			results_seen = 0;
		end else begin
			if (done) begin
				results_seen++;
				if (outcome_q.size() == 0) begin
					report_mismatch("unexpected result", 0, block_address);
				end else begin
					want = outcome_q.pop_front();
					if (block_address !== want.addr)
						report_mismatch("block_address", want.addr, block_address);
					if (success !== want.ok)
						report_mismatch("success", want.ok, success);
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_REGION_BASE) begin
					base_shadow = cfg_data;
				end else begin
					rsize_shadow = cfg_data & 32'h1FFFF;
					build_region();
				end
			end
			if (start && !busy) begin
				if (op == OP_ALLOC) begin
					want = predict_alloc(32'(request_size));
				end else begin
					want = '0;
					want.ok = predict_free(block_addr);
				end
				outcome_q.push_back(want);
			end
		end
	end

endmodule

/* tb/testbench.sv */
// first-fit block allocator testbench top: clock, reset, stimulus, watchdog, verdict
// depends on ffba_pkg, first_fit_block_allocator_top and ffba_checker
`timescale 1ns / 1ps

module testbench;
	import ffba_pkg::*;

	localparam int IDLE_LIMIT = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 op = OP_ALLOC;
	logic [REQ_W-1:0]     request_size = '0;
	logic [ADDR_W-1:0]    block_addr = '0;
	logic                 done;
	logic [ADDR_W-1:0]    block_address;
	logic                 success;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_REGION_BASE;
	logic [ADDR_W-1:0]    cfg_data = '0;
	int                   fail_count, pending, results_seen;

	// stimulus bookkeeping
	logic [31:0] live_blocks [$];
	logic [31:0] freed_blocks [$];
	logic        last_op = OP_ALLOC;
	logic [31:0] cur_base = 0;
	logic [31:0] cur_size = REGION_BYTES;
	int          idle_pct = 0;
	int          n_alloc = 0, n_free = 0, n_cfg = 0, idle_cycles = 0;

	always #5 clk = ~clk;

	first_fit_block_allocator_top DUT (.*);

	ffba_checker u_checker (.*);

	// remember every granted block so frees target real headers
	always @(posedge clk) begin
		if (done && success && last_op == OP_ALLOC) live_blocks.push_back(block_address);
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles > IDLE_LIMIT) begin
			$display("FAIL first_fit_block_allocator_top");
			$finish;
		end
	end

	task automatic send_cmd(logic cmd_op, logic [REQ_W-1:0] req, logic [31:0] addr);
		if ($urandom_range(99) < idle_pct) repeat ($urandom_range(1, 8)) @(negedge clk);
		@(negedge clk);
		start = 1'b1;
		op = cmd_op;
		request_size = req;
		block_addr = addr;
		do @(posedge clk); while (busy);
		last_op = cmd_op;
		if (cmd_op == OP_ALLOC) n_alloc++;
		else n_free++;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic drain();
		while (pending != 0 || busy) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// register writes only when idle; old block addresses no longer apply
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		drain();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		n_cfg++;
		if (idx == CFG_REGION_BASE) cur_base = val;
		else cur_size = val & 32'h1FFFF;
		live_blocks.delete();
		freed_blocks.delete();
	endtask

	// address that fails the range checks before any header is read
	function automatic logic [31:0] bad_addr();
		logic [31:0] len, a, off;
		len = (cur_size < REGION_BYTES) ? cur_size : REGION_BYTES;
		case ($urandom_range(3))
			0: a = cur_base + $urandom_range(0, 7);
			1: a = cur_base + 32'(len) - 4;
			2: a = cur_base + 8 + 4 * $urandom_range(0, 1000) + $urandom_range(1, 3);
			default: a = $urandom;
		endcase
		off = a - cur_base;
		// flipping the low address bit always misaligns the offset
		if (!(off < 8 || off[1:0] != 0 || longint'(off) + 8 > len)) a[0] = ~a[0];
		return a;
	endfunction

	task automatic free_live(int pick);
		logic [31:0] a;
		a = live_blocks[pick];
		live_blocks.delete(pick);
		freed_blocks.push_back(a);
		send_cmd(OP_FREE, '0, a);
	endtask

	task automatic random_item();
		int r;
		logic [REQ_W-1:0] req;
		r = $urandom_range(99);
		if (live_blocks.size() == 0 || r < 50) begin
			r = $urandom_range(99);
			if (r < 70) req = REQ_W'($urandom_range(0, 64));
			else if (r < 95) req = REQ_W'($urandom_range(65, 1024));
			else req = REQ_W'($urandom_range(0, 131071));
			send_cmd(OP_ALLOC, req, $urandom);
		end else if (r < 85) begin
			free_live($urandom_range(0, live_blocks.size() - 1));
		end else if (r < 92 && freed_blocks.size() != 0) begin
			send_cmd(OP_FREE, REQ_W'($urandom),
				freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
		end else begin
			send_cmd(OP_FREE, REQ_W'($urandom), bad_addr());
		end
	endtask

	initial begin
		int pct [4] = '{0, 53, 32, 0};
		logic [31:0] sizes [6] = '{32'd24, 32'd131071, 32'd8, 32'd4096, 32'd65536, 32'd1000};
		logic [31:0] bases [6] = '{32'hFFFF_FFF8, 32'h0, 32'h8000_0000, 32'h1234_5670,
			32'hFFFF_FFFF, 32'h0};
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: size extremes, split and unsplit, merge, range errors, double free
		send_cmd(OP_ALLOC, 17'd0, '0);
		send_cmd(OP_ALLOC, 17'd1, '0);
		send_cmd(OP_ALLOC, 17'd16, '0);
		send_cmd(OP_ALLOC, 17'd16, '0);
		send_cmd(OP_ALLOC, 17'd16, '0);
		send_cmd(OP_ALLOC, 17'd131071, '1);
		send_cmd(OP_ALLOC, 17'd65536, '0);
		drain();
		free_live(3);
		send_cmd(OP_ALLOC, 17'd8, '0);
		send_cmd(OP_FREE, '0, freed_blocks[0]);
		free_live(1);
		free_live(1);
		free_live(0);
		send_cmd(OP_FREE, '0, 32'h0);
		send_cmd(OP_FREE, '0, 32'h0000_000A);
		send_cmd(OP_FREE, '0, 32'h0000_FFFC);
		send_cmd(OP_FREE, '0, 32'hFFFF_FFFF);
		send_cmd(OP_ALLOC, 17'd65520, '0);
		send_cmd(OP_ALLOC, 17'd3, '0);
		drain();
		while (live_blocks.size() != 0) free_live(0);

		// random phases, each under a fresh region setting
		for (int ph = 0; ph < 6; ph++) begin
			idle_pct = pct[ph % 4];
			write_reg(CFG_REGION_BASE, bases[ph]);
			write_reg(CFG_REGION_SIZE, sizes[ph]);
			for (int i = 0; i < 140; i++) begin
				random_item();
				if (i == 70) drain();
			end
		end

		drain();
		$display("covered %0d allocate and %0d free commands, %0d register writes",
			n_alloc, n_free, n_cfg);
		$display("%0d results compared across six region settings and four idle mixes",
			results_seen);
		if (fail_count == 0) begin
			$display("PASS first_fit_block_allocator_top");
		end else begin
			$display("FAIL first_fit_block_allocator_top");
		end
		$finish;
	end

endmodule
